// ===== rtl/core/nfcs_pkg.sv =====
// nfcs_pkg: shared types, codes and constants of the nor flash command sequencer
// depends on nothing; imported by nfcs_ctrl, nfcs_emit and nor_flash_command_sequencer
package nfcs_pkg;

    localparam int ADDR_BITS    = 27;
    localparam int BUFFER_WORDS = 32;
    localparam int MAX_RES      = 7;
    localparam int RES_CNT_W    = $clog2(MAX_RES + 1);

    localparam logic [ADDR_BITS-1:0] ADDR_UNLOCK1 = ADDR_BITS'(12'h555);
    localparam logic [ADDR_BITS-1:0] ADDR_UNLOCK2 = ADDR_BITS'(12'h2AA);

    localparam logic [15:0] CMD_KEY_FIRST  = 16'h00AA;
    localparam logic [15:0] CMD_KEY_SECOND = 16'h0055;
    localparam logic [15:0] CMD_BUF_LOAD = 16'h0025;
    localparam logic [15:0] CMD_BUF_PROG = 16'h0029;
    localparam logic [15:0] CMD_SEC_ERASE = 16'h0030;
    localparam logic [15:0] CMD_ERASE_ARM = 16'h0080;
    localparam logic [15:0] CMD_ID_ENTRY = 16'h0090;
    localparam logic [15:0] CMD_WORD_PROG = 16'h00A0;
    localparam logic [15:0] CMD_RESET     = 16'h00F0;

    localparam int DQ2 = 2;
    localparam int DQ3 = 3;
    localparam int DQ5 = 5;
    localparam int DQ6 = 6;
    localparam int DQ7 = 7;

    typedef enum logic [2:0] {
        REQ_ERASE     = 3'd0,
        REQ_BUF_BEGIN = 3'd1,
        REQ_BUF_WORD  = 3'd2,
        REQ_WORD_PROG = 3'd3,
        REQ_STATUS    = 3'd4,
        REQ_RESET     = 3'd5,
        REQ_AUTOSEL   = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_ERASED = 2'd1,
        ST_TIMEOUT    = 2'd2,
        ST_REJECTED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ADDR_BITS-1:0] addr;
        logic [15:0]          data;
        logic [1:0]           status;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0]   ent;
        logic [RES_CNT_W-1:0] n;
    } plan_t;

    function automatic res_t mk_wr(input logic [ADDR_BITS-1:0] a, input logic [15:0] d);
        res_t r;
        r.kind   = KIND_WRITE;
        r.addr   = a;
        r.data   = d;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic res_t mk_rd(input logic [ADDR_BITS-1:0] a);
        res_t r;
        r.kind   = KIND_READ;
        r.addr   = a;
        r.data   = '0;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic res_t mk_done(input logic [1:0] st);
        res_t r;
        r.kind   = KIND_DONE;
        r.addr   = '0;
        r.data   = '0;
        r.status = st;
        return r;
    endfunction

endpackage

// ===== rtl/core/nfcs_ctrl.sv =====
// nfcs_ctrl: sequencer state, chip base register and per-request bus cycle planning
// depends on nfcs_pkg
module nfcs_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [nfcs_pkg::ADDR_BITS-1:0] cfg_wr_data,
    input  logic                           accept,
    input  logic [2:0]                     req_type,
    input  logic [nfcs_pkg::ADDR_BITS-1:0] addr,
    input  logic [15:0]                    data,
    input  logic [5:0]                     count,
    output nfcs_pkg::plan_t                plan
);
    import nfcs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FILL  = 3'd1,
        PH_DQ3   = 3'd2,
        PH_ERASE = 3'd3,
        PH_WRITE = 3'd4
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [1:0]           poll_reg, poll_next;
    logic [15:0]          prev_reg, prev_next;
    logic [15:0]          first_reg, first_next;
    logic [ADDR_BITS-1:0] sector_reg, sector_next;
    logic [5:0]           left_reg, left_next;
    logic [ADDR_BITS-1:0] base_reg;

    logic [ADDR_BITS-1:0] a555;
    logic [ADDR_BITS-1:0] a2aa;
    res_t                 ul1;
    res_t                 ul2;
    logic [5:0]           left_dec;
    logic                 dq6_same;
    logic                 dq2_same;

    assign a555     = base_reg + ADDR_UNLOCK1;
    assign a2aa     = base_reg + ADDR_UNLOCK2;
    assign ul1      = mk_wr(a555, CMD_KEY_FIRST);
    assign ul2      = mk_wr(a2aa, CMD_KEY_SECOND);
    assign left_dec = left_reg - 6'd1;
    assign dq6_same = first_reg[DQ6] == data[DQ6];
    assign dq2_same = first_reg[DQ2] == data[DQ2];

    always_comb
    begin
        plan        = '0;
        plan.ent[0] = mk_done(ST_REJECTED);
        plan.n      = RES_CNT_W'(1);
        phase_next  = phase_reg;
        poll_next   = poll_reg;
        prev_next   = prev_reg;
        first_next  = first_reg;
        sector_next = sector_reg;
        left_next   = left_reg;

        if (req_type == REQ_RESET)
        begin
            plan.ent[0] = ul1;
            plan.ent[1] = ul2;
            plan.ent[2] = mk_wr(a555, CMD_RESET);
            plan.ent[3] = mk_done(ST_OK);
            plan.n      = RES_CNT_W'(4);
            phase_next  = PH_IDLE;
            poll_next   = '0;
            left_next   = '0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req_type == REQ_ERASE)
                    begin
                        plan.ent[0] = ul1;
                        plan.ent[1] = ul2;
                        plan.ent[2] = mk_wr(a555, CMD_ERASE_ARM);
                        plan.ent[3] = ul1;
                        plan.ent[4] = ul2;
                        plan.ent[5] = mk_wr(addr, CMD_SEC_ERASE);
                        plan.ent[6] = mk_rd(addr);
                        plan.n      = RES_CNT_W'(7);
                        sector_next = addr;
                        phase_next  = PH_DQ3;
                        poll_next   = '0;
                    end
                    else if (req_type == REQ_BUF_BEGIN && count inside {[1:BUFFER_WORDS]})
                    begin
                        plan.ent[0] = ul1;
                        plan.ent[1] = ul2;
                        plan.ent[2] = mk_wr(addr, CMD_BUF_LOAD);
                        plan.ent[3] = mk_wr(addr, 16'(count - 6'd1));
                        plan.n      = RES_CNT_W'(4);
                        sector_next = addr;
                        left_next   = count;
                        phase_next  = PH_FILL;
                    end
                    else if (req_type == REQ_WORD_PROG)
                    begin
                        plan.ent[0] = ul1;
                        plan.ent[1] = ul2;
                        plan.ent[2] = mk_wr(a555, CMD_WORD_PROG);
                        plan.ent[3] = mk_wr(addr, data);
                        plan.ent[4] = mk_rd(addr);
                        plan.n      = RES_CNT_W'(5);
                        sector_next = addr;
                        phase_next  = PH_WRITE;
                        poll_next   = '0;
                    end
                    else if (req_type == REQ_AUTOSEL)
                    begin
                        plan.ent[0] = ul1;
                        plan.ent[1] = ul2;
                        plan.ent[2] = mk_wr(a555, CMD_ID_ENTRY);
                        plan.ent[3] = mk_done(ST_OK);
                        plan.n      = RES_CNT_W'(4);
                    end
                end
                PH_FILL:
                begin
                    if (req_type == REQ_BUF_WORD)
                    begin
                        plan.ent[0] = mk_wr(addr, data);
                        left_next   = left_dec;
                        if (left_dec == '0)
                        begin
                            plan.ent[1] = mk_wr(sector_reg, CMD_BUF_PROG);
                            plan.ent[2] = mk_rd(sector_reg);
                            plan.n      = RES_CNT_W'(3);
                            phase_next  = PH_WRITE;
                            poll_next   = '0;
                        end
                    end
                end
                PH_DQ3:
                begin
                    if (req_type == REQ_STATUS)
                    begin
                        plan.ent[0] = mk_rd(sector_reg);
                        if (data[DQ3])
                        begin
                            phase_next = PH_ERASE;
                            poll_next  = '0;
                        end
                    end
                end
                PH_WRITE:
                begin
                    if (req_type == REQ_STATUS)
                    begin
                        plan.ent[0] = mk_rd(sector_reg);
                        if (poll_reg == 2'd0)
                        begin
                            first_next = data;
                            poll_next  = 2'd1;
                        end
                        else
                        begin
                            prev_next = data;
                            poll_next = 2'd0;
                            if (dq6_same)
                            begin
                                plan.ent[0] = mk_done(ST_OK);
                                phase_next  = PH_IDLE;
                            end
                        end
                    end
                end
                PH_ERASE:
                begin
                    if (req_type == REQ_STATUS)
                    begin
                        plan.ent[0] = mk_rd(sector_reg);
                        if (poll_reg == 2'd0)
                        begin
                            prev_next = data;
                            poll_next = (data[DQ7] || data[DQ5]) ? 2'd1 : 2'd0;
                        end
                        else if (poll_reg == 2'd1)
                        begin
                            first_next = data;
                            poll_next  = 2'd2;
                        end
                        else if (prev_reg[DQ7] || !dq6_same)
                        begin
                            plan.ent[0] = ul1;
                            plan.ent[1] = ul2;
                            plan.ent[2] = mk_wr(a555, CMD_RESET);
                            if (prev_reg[DQ7])
                                plan.ent[3] = mk_done((dq6_same && dq2_same) ? ST_OK
                                                                             : ST_NOT_ERASED);
                            else
                                plan.ent[3] = mk_done(ST_TIMEOUT);
                            plan.n     = RES_CNT_W'(4);
                            phase_next = PH_IDLE;
                            poll_next  = '0;
                        end
                        else
                        begin
                            poll_next = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            poll_reg   <= '0;
            prev_reg   <= '0;
            first_reg  <= '0;
            sector_reg <= '0;
            left_reg   <= '0;
            base_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                base_reg <= cfg_wr_data;
            if (accept)
            begin
                phase_reg  <= phase_next;
                poll_reg   <= poll_next;
                prev_reg   <= prev_next;
                first_reg  <= first_next;
                sector_reg <= sector_next;
                left_reg   <= left_next;
            end
        end
    end

endmodule

// ===== rtl/core/nfcs_emit.sv =====
// nfcs_emit: result shift register that hands out one bus cycle or done code per handshake
// depends on nfcs_pkg
module nfcs_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  nfcs_pkg::plan_t plan,
    input  logic            take,
    output logic            valid,
    output logic            final_res,
    output nfcs_pkg::res_t  head
);
    import nfcs_pkg::*;

    res_t [MAX_RES-1:0]   ent_reg;
    logic [RES_CNT_W-1:0] cnt_reg;

    assign valid     = cnt_reg != '0;
    assign final_res = cnt_reg == RES_CNT_W'(1);
    assign head      = ent_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= plan.n;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - RES_CNT_W'(1);
        end
    end

    // payload shift line, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            ent_reg <= plan.ent;
        else if (take)
            ent_reg <= {res_t'('0), ent_reg[MAX_RES-1:1]};
    end

endmodule

// ===== rtl/core/nor_flash_command_sequencer.sv =====
// Command sequencer for a NOR flash with the two-write unlock command set. A request is
// decoded in the cycle it is accepted into a list of one to seven results (bus writes,
// status read requests, a done code) that leave one per cycle on the output channel
// while out_ready is high; the next request is taken in the cycle the final result of
// the previous one is taken. Results per request: 7 for a sector erase, 5 for a
// word program, 4 for buffer begin, reset, autoselect and the end of an erase, 3 for the
// final buffer word, 1 for other buffer words, status reads and rejected requests.
// The single output port thus paces the requests. chip_base may be written only while idle.
// depends on nfcs_pkg, nfcs_ctrl, nfcs_emit
module nor_flash_command_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [nfcs_pkg::ADDR_BITS-1:0] cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     req_type,
    input  logic [nfcs_pkg::ADDR_BITS-1:0] addr,
    input  logic [15:0]                    data,
    input  logic [5:0]                     count,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic [nfcs_pkg::ADDR_BITS-1:0] bus_addr,
    output logic [15:0]                    bus_data,
    output logic [1:0]                     status,
    output logic                           last
);
    import nfcs_pkg::*;

    plan_t plan;
    res_t  head;
    logic  accept;
    logic  take;
    logic  final_res;

    assign take     = out_valid && out_ready;
    assign in_ready = !out_valid || (out_ready && final_res);
    assign accept   = in_valid && in_ready;

    nfcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .req_type    (req_type),
        .addr        (addr),
        .data        (data),
        .count       (count),
        .plan        (plan)
    );

    nfcs_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .plan      (plan),
        .take      (take),
        .valid     (out_valid),
        .final_res (final_res),
        .head      (head)
    );

    assign kind     = head.kind;
    assign bus_addr = head.addr;
    assign bus_data = head.data;
    assign status   = head.status;
    assign last     = final_res;

endmodule
